// ===== rtl/core/kcv_pkg.sv =====
// Package for the 2D constant-velocity tracker: widths, register indexes,
// per-axis state type, sequencer states and Q16.16 helper functions. No dependencies.
`timescale 1ns / 1ps

package kcv_pkg;

    localparam int QFRAC = 16;
    localparam int NUM_REGS = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_POS_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_POS_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOT_POS_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOT_POS_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOT_VEL_X  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MOT_VEL_Y  = 3'd7;

    localparam logic signed [31:0] INIT_VEL_VAR = 32'sd65536000;

    // Divider: 48-bit dividend magnitude, one quotient bit per cycle
    localparam int DIV_N = 48;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic signed [31:0] p;
        logic signed [31:0] v;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } axis_state_t;

    typedef struct packed {
        logic start;     // begin one item on this lane
        logic reload;    // load initial state first
    } lane_ctrl_t;

    typedef struct packed {
        logic done;      // lane finished, state registers hold new values
        logic zero_s;    // innovation variance was zero
    } lane_stat_t;

    typedef enum logic [3:0] {
        L_IDLE, L_PRED1, L_PRED2, L_PRED3, L_PRED4, L_DIVP, L_DIVV,
        L_UPD1, L_UPD2, L_UPD3, L_UPD4, L_UPD5
    } lane_state_t;

    typedef enum logic [1:0] {
        T_IDLE, T_RUN, T_OUT
    } top_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else return v[31:0];
    endfunction

    function automatic logic signed [31:0] satv(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        else if (v < 66'sd0) return 32'sd0;
        else return v[31:0];
    endfunction

    // floor(prod / 2^16), prod a signed 64-bit product
    function automatic logic signed [65:0] qshift(input logic signed [63:0] prod);
        return 66'(prod >>> QFRAC);
    endfunction

endpackage

// ===== rtl/core/kalman_constant_velocity_2d.sv =====
// Top level of the 2D constant-velocity tracker: config registers, two axis
// lanes and the merge/output stage. Depends on kcv_pkg and kcv_lane.
//
//  channel | ports                              | carries
//  s_      | s_tvalid s_tready s_tdata s_tuser  | meas_x, meas_y; tuser = cmd
//  m_      | m_tvalid m_tready m_tdata m_tuser  | estimates and covariances; tuser = zero_gain_flag
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data | register writes
//
// m_tvalid rises once both lanes are done and the result word is formed.
// Two 48-step gain divisions run in series on each lane; both lanes run in parallel.
// A zero innovation variance on an axis skips the divisions of that lane.
// aresetn is synchronous; it loads the register reset values and initial state.
// The result sits in an output register; the next item is taken once it is transferred.
`timescale 1ns / 1ps

module kalman_constant_velocity_2d (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // meas_x [31:0], meas_y [63:32]
    input  logic         s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [319:0] m_tdata,   // est_x, est_y, est_vx, est_vy, var_x(31), cov_x_vx,
                                    // var_vx(31), var_y(31), cov_y_vy, var_vy(31), pad
    output logic         m_tuser,   // zero_gain_flag
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    kcv_pkg::top_state_t  state_reg, state_next;
    logic [30:0]          ts_reg, mn_reg;
    logic signed [31:0]   ipx_reg, ipy_reg, mpx_reg, mpy_reg, mvx_reg, mvy_reg;
    logic signed [31:0]   mx_reg, my_reg;
    logic                 cmd_reg;
    logic                 dx_reg, dy_reg, dx_next, dy_next;
    kcv_pkg::lane_stat_t  sx, sy;
    kcv_pkg::axis_state_t ax, ay;
    logic [319:0]         out_reg, out_next;
    logic                 flag_reg, flag_next, fx_reg, fy_reg, fx_next, fy_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == kcv_pkg::T_IDLE);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg  <= 31'd6554;
            mn_reg  <= 31'd6554;
            ipx_reg <= -32'sd262144;
            ipy_reg <= 32'sd524288;
            mpx_reg <= '0;
            mpy_reg <= '0;
            mvx_reg <= '0;
            mvy_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                kcv_pkg::REG_TIME_STEP:  ts_reg  <= cfg_data[30:0];
                kcv_pkg::REG_MEAS_NOISE: mn_reg  <= cfg_data[30:0];
                kcv_pkg::REG_INIT_POS_X: ipx_reg <= cfg_data;
                kcv_pkg::REG_INIT_POS_Y: ipy_reg <= cfg_data;
                kcv_pkg::REG_MOT_POS_X:  mpx_reg <= cfg_data;
                kcv_pkg::REG_MOT_POS_Y:  mpy_reg <= cfg_data;
                kcv_pkg::REG_MOT_VEL_X:  mvx_reg <= cfg_data;
                kcv_pkg::REG_MOT_VEL_Y:  mvy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // capture the accepted item
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mx_reg  <= s_tdata[31:0];
            my_reg  <= s_tdata[63:32];
            cmd_reg <= s_tuser;
        end
    end

    always_comb begin
        state_next  = state_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        fx_next     = fx_reg;
        fy_next     = fy_reg;
        out_next    = out_reg;
        flag_next   = flag_reg;
        unique case (state_reg)
            kcv_pkg::T_IDLE: begin
                if (s_tvalid) begin
                    // lanes start in the next cycle, once the item is held
                    state_next = kcv_pkg::T_RUN;
                    dx_next = 1'b0;
                    dy_next = 1'b0;
                end
            end
            kcv_pkg::T_RUN: begin
                if (sx.done) begin
                    dx_next = 1'b1;
                    fx_next = sx.zero_s;
                end
                if (sy.done) begin
                    dy_next = 1'b1;
                    fy_next = sy.zero_s;
                end
                if ((dx_reg || sx.done) && (dy_reg || sy.done)) begin
                    // merge the zero flags of both lanes and go on to the output state
                    flag_next  = (dx_reg ? fx_reg : sx.zero_s) || (dy_reg ? fy_reg : sy.zero_s);
                    state_next = kcv_pkg::T_OUT;
                end
            end
            kcv_pkg::T_OUT: begin
                out_next = {4'd0, ay.c[30:0], ay.b, ay.a[30:0], ax.c[30:0], ax.b,
                            ax.a[30:0], ay.v, ax.v, ay.p, ax.p};
                if (m_tvalid && m_tready) begin
                    state_next = kcv_pkg::T_IDLE;
                end
            end
            default: state_next = kcv_pkg::T_IDLE;
        endcase
    end

    // launch the lanes the cycle after the transfer in
    logic start_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 1'b0;
        end else begin
            start_reg <= s_tvalid && s_tready;
        end
    end

    kcv_pkg::lane_ctrl_t lc;
    assign lc.start  = start_reg;
    assign lc.reload = cmd_reg;

    kcv_lane u_lane_x (
        .aclk (aclk), .aresetn (aresetn), .ctrl (lc),
        .time_step (ts_reg), .meas_noise (mn_reg), .init_pos (ipx_reg),
        .motion_pos (mpx_reg), .motion_vel (mvx_reg), .meas (mx_reg),
        .st (ax), .stat (sx)
    );

    kcv_lane u_lane_y (
        .aclk (aclk), .aresetn (aresetn), .ctrl (lc),
        .time_step (ts_reg), .meas_noise (mn_reg), .init_pos (ipy_reg),
        .motion_pos (mpy_reg), .motion_vel (mvy_reg), .meas (my_reg),
        .st (ay), .stat (sy)
    );

    logic mvalid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= kcv_pkg::T_IDLE;
            dx_reg     <= 1'b0;
            dy_reg     <= 1'b0;
            fx_reg     <= 1'b0;
            fy_reg     <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            fx_reg     <= fx_next;
            fy_reg     <= fy_next;
            // result valid in the cycle after the output state is entered, once the word is formed
            mvalid_reg <= (state_reg == kcv_pkg::T_OUT) && !(mvalid_reg && m_tready);
        end
        out_reg  <= out_next;
        flag_reg <= flag_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = flag_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input taken while result pending");
    a_lanes_together: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |=> (state_reg == kcv_pkg::T_RUN))
        else $error("lanes started outside run");
    a_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> state_reg == kcv_pkg::T_OUT || state_reg == kcv_pkg::T_IDLE)
        else $error("result valid in wrong state");

endmodule

// ===== rtl/core/kcv_div.sv =====
// Iterative signed divider, one quotient bit a cycle, quotient truncated toward zero.
// Depends on kcv_pkg.
`timescale 1ns / 1ps

module kcv_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [kcv_pkg::DIV_N-1:0] dividend,
    input  logic        [32:0]             divisor,   // positive
    output logic                           done,
    output logic signed [kcv_pkg::DIV_N:0] quotient
);

    logic [kcv_pkg::DIV_N-1:0]     num_reg, num_next;
    logic [33:0]                   rem_reg, rem_next;
    logic [kcv_pkg::DIV_N-1:0]     quo_reg, quo_next;
    logic [32:0]                   den_reg, den_next;
    logic                          neg_reg, neg_next;
    logic [kcv_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [34:0]                   trial;

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start) begin
            neg_next  = dividend[kcv_pkg::DIV_N-1];
            num_next  = dividend[kcv_pkg::DIV_N-1] ? kcv_pkg::DIV_N'(-dividend)
                                                   : kcv_pkg::DIV_N'(dividend);
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            trial = {rem_reg, num_reg[kcv_pkg::DIV_N-1]} - {2'b00, den_reg};
            if (!trial[34]) begin
                rem_next = trial[33:0];
                quo_next = {quo_reg[kcv_pkg::DIV_N-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[32:0], num_reg[kcv_pkg::DIV_N-1]};
                quo_next = {quo_reg[kcv_pkg::DIV_N-2:0], 1'b0};
            end
            num_next = {num_reg[kcv_pkg::DIV_N-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == kcv_pkg::DIV_CNT_W'(kcv_pkg::DIV_N - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

// ===== rtl/core/kcv_lane.sv =====
// One axis of the tracker: predict, two gain divisions, update, all sequenced
// over a shared multiplier. Depends on kcv_pkg and kcv_div.
`timescale 1ns / 1ps

module kcv_lane (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  kcv_pkg::lane_ctrl_t  ctrl,
    input  logic [30:0]          time_step,
    input  logic [30:0]          meas_noise,
    input  logic signed [31:0]   init_pos,
    input  logic signed [31:0]   motion_pos,
    input  logic signed [31:0]   motion_vel,
    input  logic signed [31:0]   meas,
    output kcv_pkg::axis_state_t st,
    output kcv_pkg::lane_stat_t  stat
);

    kcv_pkg::lane_state_t  state_reg, state_next;
    kcv_pkg::axis_state_t  st_reg, st_next;
    logic signed [31:0]    b1_reg, b1_next, a1_reg, a1_next, c1_reg, c1_next;
    logic signed [31:0]    kp_reg, kp_next, kv_reg, kv_next, y_reg, y_next;
    logic signed [65:0]    acc_reg, acc_next;
    logic                  zero_reg, zero_next, done_reg, done_next;
    logic                  div_start;
    logic signed [kcv_pkg::DIV_N-1:0] div_num;
    logic [32:0]           div_den;
    logic                  div_done;
    logic signed [kcv_pkg::DIV_N:0] div_q;
    logic signed [31:0]    mop_a, mop_b;
    logic signed [63:0]    prod;
    logic signed [31:0]    dt_s;

    assign dt_s = $signed({1'b0, time_step});
    assign prod = mop_a * mop_b;
    assign div_den = 33'(a1_reg) + 33'(meas_noise);

    kcv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        b1_next    = b1_reg;
        a1_next    = a1_reg;
        c1_next    = c1_reg;
        kp_next    = kp_reg;
        kv_next    = kv_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        zero_next  = zero_reg;
        done_next  = 1'b0;
        div_start  = 1'b0;
        div_num    = '0;
        mop_a      = dt_s;
        mop_b      = st_reg.v;
        unique case (state_reg)
            kcv_pkg::L_IDLE: begin
                if (ctrl.start) begin
                    if (ctrl.reload) begin
                        st_next.p = init_pos;
                        st_next.v = '0;
                        st_next.a = '0;
                        st_next.b = '0;
                        st_next.c = kcv_pkg::INIT_VEL_VAR;
                    end
                    state_next = kcv_pkg::L_PRED1;
                end
            end
            kcv_pkg::L_PRED1: begin
                // position and velocity prediction
                mop_a = dt_s;
                mop_b = st_reg.v;
                st_next.p = kcv_pkg::sat32(66'(kcv_pkg::sat32(66'(st_reg.p)
                    + kcv_pkg::qshift(prod))) + 66'(motion_pos));
                st_next.v = kcv_pkg::sat32(66'(st_reg.v) + 66'(motion_vel));
                state_next = kcv_pkg::L_PRED2;
            end
            kcv_pkg::L_PRED2: begin
                mop_a = dt_s;
                mop_b = st_reg.c;
                b1_next = kcv_pkg::sat32(66'(st_reg.b) + kcv_pkg::qshift(prod));
                c1_next = kcv_pkg::satv(66'(st_reg.c));
                state_next = kcv_pkg::L_PRED3;
            end
            kcv_pkg::L_PRED3: begin
                mop_a = dt_s;
                mop_b = st_reg.b;
                acc_next = 66'(st_reg.a) + kcv_pkg::qshift(prod);
                state_next = kcv_pkg::L_PRED4;
            end
            kcv_pkg::L_PRED4: begin
                mop_a = dt_s;
                mop_b = b1_reg;
                a1_next = kcv_pkg::satv(acc_reg + kcv_pkg::qshift(prod));
                state_next = kcv_pkg::L_DIVP;
            end
            kcv_pkg::L_DIVP: begin
                // a1 is final here; check S and launch the first division
                if (div_den == '0) begin
                    zero_next = 1'b1;
                    st_next.a = a1_reg;
                    st_next.b = b1_reg;
                    st_next.c = c1_reg;
                    done_next = 1'b1;
                    state_next = kcv_pkg::L_IDLE;
                end else begin
                    zero_next = 1'b0;
                    div_start = 1'b1;
                    div_num = {a1_reg, 16'd0};
                    y_next = kcv_pkg::sat32(66'(meas) - 66'(st_reg.p));
                    state_next = kcv_pkg::L_DIVV;
                end
            end
            kcv_pkg::L_DIVV: begin
                if (div_done) begin
                    kp_next = kcv_pkg::sat32(66'(div_q));
                    div_start = 1'b1;
                    div_num = {b1_reg, 16'd0};
                    state_next = kcv_pkg::L_UPD1;
                end
            end
            kcv_pkg::L_UPD1: begin
                mop_a = kp_reg;
                mop_b = y_reg;
                if (div_done) begin
                    kv_next = kcv_pkg::sat32(66'(div_q));
                    st_next.p = kcv_pkg::sat32(66'(st_reg.p) + kcv_pkg::qshift(prod));
                    state_next = kcv_pkg::L_UPD2;
                end
            end
            kcv_pkg::L_UPD2: begin
                mop_a = kv_reg;
                mop_b = y_reg;
                st_next.v = kcv_pkg::sat32(66'(st_reg.v) + kcv_pkg::qshift(prod));
                state_next = kcv_pkg::L_UPD3;
            end
            kcv_pkg::L_UPD3: begin
                mop_a = kp_reg;
                mop_b = a1_reg;
                st_next.a = kcv_pkg::satv(66'(a1_reg) - kcv_pkg::qshift(prod));
                state_next = kcv_pkg::L_UPD4;
            end
            kcv_pkg::L_UPD4: begin
                mop_a = kv_reg;
                mop_b = b1_reg;
                st_next.c = kcv_pkg::satv(66'(c1_reg) - kcv_pkg::qshift(prod));
                state_next = kcv_pkg::L_UPD5;
            end
            kcv_pkg::L_UPD5: begin
                mop_a = kp_reg;
                mop_b = b1_reg;
                st_next.b = kcv_pkg::sat32(66'(b1_reg) - kcv_pkg::qshift(prod));
                done_next = 1'b1;
                state_next = kcv_pkg::L_IDLE;
            end
            default: state_next = kcv_pkg::L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kcv_pkg::L_IDLE;
            done_reg  <= 1'b0;
            zero_reg  <= 1'b0;
            st_reg.p  <= init_pos;
            st_reg.v  <= '0;
            st_reg.a  <= '0;
            st_reg.b  <= '0;
            st_reg.c  <= kcv_pkg::INIT_VEL_VAR;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            zero_reg  <= zero_next;
            st_reg    <= st_next;
        end
        b1_reg  <= b1_next;
        a1_reg  <= a1_next;
        c1_reg  <= c1_next;
        kp_reg  <= kp_next;
        kv_reg  <= kv_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    assign st          = st_reg;
    assign stat.done   = done_reg;
    assign stat.zero_s = zero_reg;

    a_var_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> (st_reg.a >= 0 && st_reg.c >= 0))
        else $error("variance negative");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.start && state_reg != kcv_pkg::L_IDLE) |-> 1'b0)
        else $error("start while busy");
    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> state_reg == kcv_pkg::L_IDLE)
        else $error("done outside idle");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the 2D constant-velocity tracker: drives measurements
// and register writes, predicts every estimate in a scoreboard class and checks each
// result transfer. Depends on kcv_pkg and kalman_constant_velocity_2d.
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT = 6000;   // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES = 150;  // extra wait after the last estimate is back

    typedef struct {
        longint p, v, a, b, c;
    } track_t;

    // Tracker state, register copy and queue of predicted results
    class track_scoreboard;
        longint time_step, meas_noise;
        longint init_x, init_y, mot_px, mot_py, mot_vx, mot_vy;
        track_t trk_x, trk_y;
        logic [319:0] est_q[$];
        bit flag_q[$];
        int errors;
        int results;
        int restarts;
        int zero_gains;

        function new();
            time_step = 6554;
            meas_noise = 6554;
            init_x = -262144;
            init_y = 524288;
            mot_px = 0; mot_py = 0; mot_vx = 0; mot_vy = 0;
            errors = 0; results = 0; restarts = 0; zero_gains = 0;
            restart_tracks();
        endfunction

        function void restart_tracks();
            trk_x = '{init_x, 0, 0, 0, 1000 * 65536};
            trk_y = '{init_y, 0, 0, 0, 1000 * 65536};
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                kcv_pkg::REG_TIME_STEP:  time_step = longint'(val[30:0]);
                kcv_pkg::REG_MEAS_NOISE: meas_noise = longint'(val[30:0]);
                kcv_pkg::REG_INIT_POS_X: init_x = longint'(signed'(val));
                kcv_pkg::REG_INIT_POS_Y: init_y = longint'(signed'(val));
                kcv_pkg::REG_MOT_POS_X:  mot_px = longint'(signed'(val));
                kcv_pkg::REG_MOT_POS_Y:  mot_py = longint'(signed'(val));
                kcv_pkg::REG_MOT_VEL_X:  mot_vx = longint'(signed'(val));
                kcv_pkg::REG_MOT_VEL_Y:  mot_vy = longint'(signed'(val));
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint clampv(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < 0) return 0;
            return v;
        endfunction

        // Q16.16 product, rounded toward minus infinity
        function longint qmul(longint u, longint v);
            return (u * v) >>> 16;
        endfunction

        // Predict then update one axis; returns 1 when the innovation variance is zero
        function bit run_axis(inout track_t s, input longint meas, input longint up,
                              input longint uv);
            longint b1, a1, c1, sv, kp, kv, innov;
            s.p = clamp32(clamp32(s.p + qmul(time_step, s.v)) + up);
            s.v = clamp32(s.v + uv);
            b1 = clamp32(s.b + qmul(time_step, s.c));
            a1 = clampv(s.a + qmul(time_step, s.b) + qmul(time_step, b1));
            c1 = clampv(s.c);
            sv = a1 + meas_noise;
            if (sv == 0) begin
                s.a = a1; s.b = b1; s.c = c1;
                return 1;
            end
            kp = clamp32((a1 * 65536) / sv);
            kv = clamp32((b1 * 65536) / sv);
            innov = clamp32(meas - s.p);
            s.p = clamp32(s.p + qmul(kp, innov));
            s.v = clamp32(s.v + qmul(kv, innov));
            s.a = clampv(a1 - qmul(kp, a1));
            s.b = clamp32(b1 - qmul(kp, b1));
            s.c = clampv(c1 - qmul(kv, b1));
            return 0;
        endfunction

        // Note an accepted measurement and queue the estimate it must produce
        function void note_measurement(bit restart, logic [31:0] mx, logic [31:0] my);
            bit zx, zy;
            logic [319:0] est;
            if (restart) begin
                restart_tracks();
                restarts++;
            end
            zx = run_axis(trk_x, longint'(signed'(mx)), mot_px, mot_vx);
            zy = run_axis(trk_y, longint'(signed'(my)), mot_py, mot_vy);
            est = {4'b0, trk_y.c[30:0], trk_y.b[31:0], trk_y.a[30:0], trk_x.c[30:0],
                   trk_x.b[31:0], trk_x.a[30:0], trk_y.v[31:0], trk_x.v[31:0],
                   trk_y.p[31:0], trk_x.p[31:0]};
            est_q.push_back(est);
            flag_q.push_back(zx | zy);
            if (zx | zy) zero_gains++;
        endfunction

        task report(string what, longint got, longint want);
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
            errors++;
        endtask

        function void split(logic [319:0] d, output longint f[10]);
            f[0] = d[31:0];    f[1] = d[63:32];   f[2] = d[95:64];   f[3] = d[127:96];
            f[4] = d[158:128]; f[5] = d[190:159]; f[6] = d[221:191]; f[7] = d[252:222];
            f[8] = d[284:253]; f[9] = d[315:285];
        endfunction

        task check_estimate(logic [319:0] got, logic got_flag);
            string names[10] = '{"est_x", "est_y", "est_vx", "est_vy", "var_x", "cov_x_vx",
                                 "var_vx", "var_y", "cov_y_vy", "var_vy"};
            longint g[10], w[10];
            logic [319:0] want;
            bit want_flag;
            results++;
            if (est_q.size() == 0) begin
                report("unexpected result", got[31:0], 0);
                return;
            end
            want = est_q.pop_front();
            want_flag = flag_q.pop_front();
            split(got, g);
            split(want, w);
            for (int i = 0; i < 10; i++)
                if (g[i] != w[i]) report(names[i], g[i], w[i]);
            if (got[319:316] != 4'b0) report("padding", got[319:316], 0);
            if (got_flag !== want_flag) report("zero_gain_flag", got_flag, want_flag);
        endtask

        function int pending();
            return est_q.size();
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [319:0] m_tdata;
    logic         m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    track_scoreboard tracker;
    int send_idle_pct;   // chance in a hundred that the sender idles a cycle
    int recv_stall_pct;  // chance in a hundred that the receiver stalls a cycle
    bit rx_hold;         // long receiver hold-off in progress
    int idle_cycles;
    int items_sent;
    logic [31:0] regs[8];

    kalman_constant_velocity_2d dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: check every result transfer, then pick the next tready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_estimate(m_tdata, m_tuser);
        m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one measurement, idle first at random, hold until the transfer
    task send_measurement(bit restart, logic [31:0] mx, logic [31:0] my);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= restart;
        s_tdata <= {my, mx};
        do @(posedge aclk); while (!s_tready);
        tracker.note_measurement(restart, mx, my);
        items_sent++;
    endtask

    // Wait until every estimate is back and the block is idle
    task drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Drain, write all eight registers from regs[], then drop the channel
    task load_registers();
        drain();
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= regs[i];
            do @(posedge aclk); while (!cfg_ready);
            tracker.set_reg(3'(i), regs[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function logic [31:0] small_signed(int span);
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    // Mostly tracking-sized settings; now and then full-range values
    task pick_registers();
        bit wild;
        wild = ($urandom_range(3) == 0);
        regs[kcv_pkg::REG_TIME_STEP] = wild ? {1'b0, $urandom()} >> 1
                                            : $urandom_range(131072);
        regs[kcv_pkg::REG_MEAS_NOISE] = wild ? $urandom() & 32'h7fffffff
                                             : $urandom_range(1 << 20);
        regs[kcv_pkg::REG_INIT_POS_X] = wild ? $urandom() : small_signed(1 << 22);
        regs[kcv_pkg::REG_INIT_POS_Y] = wild ? $urandom() : small_signed(1 << 22);
        for (int i = 4; i < 8; i++)
            regs[i] = wild ? $urandom() : ($urandom_range(1) ? small_signed(4096) : 0);
    endtask

    // Measurements near a slowly moving target; some noise and full-range values
    task random_measurements(int count);
        logic [31:0] mx, my;
        int tx, ty;
        tx = $signed(small_signed(1 << 20));
        ty = $signed(small_signed(1 << 20));
        for (int n = 0; n < count; n++) begin
            tx += $urandom_range(2000) - 1000;
            ty += $urandom_range(2000) - 1000;
            if ($urandom_range(9) == 0) begin
                mx = $urandom(); my = $urandom();
            end else begin
                mx = 32'(tx) + small_signed(20000);
                my = 32'(ty) + small_signed(20000);
            end
            send_measurement($urandom_range(24) == 0, mx, my);
        end
    endtask

    task set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
        endcase
    endtask

    initial begin
        tracker = new();
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        m_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        rx_hold = 1'b0;
        idle_cycles = 0;
        items_sent = 0;
        set_idling(0);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: track from the start, then measurement extremes
        send_measurement(1'b0, 32'hfffc0000, 32'h00080000);
        send_measurement(1'b0, 32'h7fffffff, 32'h80000000);
        send_measurement(1'b0, 32'h80000000, 32'h7fffffff);
        send_measurement(1'b1, 32'h00000000, 32'hffffffff);
        send_measurement(1'b0, 32'haaaaaaaa, 32'h55555555);
        send_measurement(1'b0, 32'h55555555, 32'haaaaaaaa);

        // Zero interval and zero noise: innovation variance is zero
        regs = '{32'h0, 32'h0, 32'h00010000, 32'hffff0000, 32'h0, 32'h0, 32'h0, 32'h0};
        load_registers();
        send_measurement(1'b1, 32'h00100000, 32'h00200000);
        send_measurement(1'b0, 32'h7fffffff, 32'h80000000);
        send_measurement(1'b1, 32'h0, 32'h0);

        // Largest interval and noise, extreme motion: drive every sum into saturation
        regs = '{32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff};
        load_registers();
        send_measurement(1'b1, 32'h80000000, 32'h7fffffff);
        send_measurement(1'b0, 32'h7fffffff, 32'h80000000);
        send_measurement(1'b0, 32'h0, 32'h0);
        send_measurement(1'b0, 32'h12345678, 32'hedcba987);

        // Large interval, tiny noise: variances go negative and clamp at zero
        regs = '{32'h00ffffff, 32'h1, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
        load_registers();
        send_measurement(1'b1, 32'h7fffffff, 32'h80000000);
        for (int i = 0; i < 5; i++) send_measurement(1'b0, $urandom(), $urandom());

        // Random part: each idling style under two register settings
        for (int chunk = 0; chunk < 8; chunk++) begin
            pick_registers();
            load_registers();
            set_idling(chunk % 4);
            if (chunk == 4) begin
                // Hold the receiver off while items keep coming, so the block backs up
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (1500) @(posedge aclk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            send_measurement(1'b1, small_signed(1 << 20), small_signed(1 << 20));
            random_measurements(172);
        end

        drain();
        $display("Sent %0d measurements (%0d restarts) across 12 register settings",
                 items_sent, tracker.restarts);
        $display("Checked %0d estimates, %0d with a zero gain, %0d mismatches",
                 tracker.results, tracker.zero_gains, tracker.errors);
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/kcv_pkg.sv
rtl/core/kcv_div.sv
rtl/core/kcv_lane.sv
rtl/core/kalman_constant_velocity_2d.sv
test/testbench.sv
